>>> hw/rtl/rpt_pkg.sv
// ----------------------------------------------------------------------------
// rpt_pkg: shared types and constants
// opcodes, modes and the command word that the front hands to the back
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int IDX_W             = 64;
  localparam int BUDGET_W          = 32;
  localparam int ENTRY_W           = 16;
  localparam int BYTES_W           = 32;
  localparam int INFLIGHT_CAPACITY = 256;
  localparam int CNT_W             = $clog2(INFLIGHT_CAPACITY + 1);
  localparam int QUEUE_DEPTH       = 4;
  localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PROBE     = 3'd0,
    OP_REPLICATE = 3'd1,
    OP_SNAPSHOT  = 3'd2,
    OP_SENT      = 3'd3,
    OP_COMMIT    = 3'd4,
    OP_ACK       = 3'd5,
    OP_REJECT    = 3'd6,
    OP_QUERY     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MODE_PROBE     = 2'd0,
    MODE_REPLICATE = 2'd1,
    MODE_SNAPSHOT  = 2'd2
  } mode_t;

  // classified event, with the state-independent arithmetic done up front
  typedef struct packed {
    op_t                 op;
    logic [IDX_W-1:0]    idx;
    logic [IDX_W-1:0]    idx_p1;
    logic [IDX_W-1:0]    hint_min;   // min(idx, hint + 1)
    logic [ENTRY_W-1:0]  entries;
    logic                entries_nz;
    logic [BYTES_W-1:0]  bytes;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hw/rtl/rpt_front.sv
// ----------------------------------------------------------------------------
// rpt_front: input acceptance and event classification
// accepts items when the queue has room and precomputes index arithmetic
// ----------------------------------------------------------------------------
module rpt_front import rpt_pkg::*; (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_opcode,
  input  logic [IDX_W-1:0]    in_log_index,
  input  logic [IDX_W-1:0]    in_hint_index,
  input  logic [ENTRY_W-1:0]  in_entry_count,
  input  logic [BYTES_W-1:0]  in_byte_count,
  input  q_status_t           q_status,
  output logic                q_push,
  output cmd_t                q_cmd
);

  logic [IDX_W-1:0] hint_p1;

  assign in_ready = !q_status.full;
  assign q_push   = in_valid && !q_status.full;
  assign hint_p1  = in_hint_index + IDX_W'(1);

  always_comb begin
    q_cmd            = '0;
    q_cmd.op         = op_t'(in_opcode);
    q_cmd.idx        = in_log_index;
    q_cmd.idx_p1     = in_log_index + IDX_W'(1);
    q_cmd.hint_min   = (in_log_index < hint_p1) ? in_log_index : hint_p1;
    q_cmd.entries    = in_entry_count;
    q_cmd.entries_nz = (in_entry_count != '0);
    q_cmd.bytes      = in_byte_count;
  end

endmodule

>>> hw/rtl/rpt_queue.sv
// ----------------------------------------------------------------------------
// rpt_queue: short command queue
// decouples the front from the back so each side can stall on its own
// ----------------------------------------------------------------------------
module rpt_queue import rpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_t       push_cmd,
  input  logic       pop,
  output cmd_t       head_cmd,
  output q_status_t  status
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + QCNT_W'(1))
    else $error("queue count missed a push");
`endif

endmodule

>>> hw/rtl/rpt_back.sv
// ----------------------------------------------------------------------------
// rpt_back: progress state and event execution
// applies one queued event per cycle unless output stalls; registers result
// ----------------------------------------------------------------------------
module rpt_back import rpt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [BUDGET_W-1:0] cfg_data,
  input  q_status_t           q_status,
  input  cmd_t                head_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_mode_now,
  output logic [IDX_W-1:0]    out_next_index,
  output logic [IDX_W-1:0]    out_match_index,
  output logic [IDX_W-1:0]    out_commit_sent_index,
  output logic                out_accepted,
  output logic                out_paused,
  output logic                out_error_flag
);

  logic [BUDGET_W-1:0] budget_r;
  mode_t               mode_r, mode_nxt;
  logic [IDX_W-1:0]    next_r, next_nxt;
  logic [IDX_W-1:0]    match_r, match_nxt;
  logic [IDX_W-1:0]    pend_r, pend_nxt;
  logic [IDX_W-1:0]    commit_r, commit_nxt;
  logic                paused_r, paused_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    bytes_r, bytes_nxt;
  logic                acc, err;

  logic                out_valid_r;
  logic [1:0]          out_mode_r;
  logic [IDX_W-1:0]    out_next_r, out_match_r, out_commit_r;
  logic                out_acc_r, out_paused_r, out_err_r;

  logic [IDX_W-1:0]    match_p1, pend_p1, next_m1, n_probe, n_rej;
  logic [IDX_W:0]      bytes_sum;
  logic [IDX_W-1:0]    bytes_sat;

  assign q_pop    = !q_status.empty && (!out_valid_r || out_ready);
  assign match_p1 = match_r + IDX_W'(1);
  assign pend_p1  = pend_r + IDX_W'(1);
  assign next_m1  = next_r - IDX_W'(1);
  assign n_probe  = (mode_r == MODE_SNAPSHOT && pend_p1 > match_p1) ? pend_p1 : match_p1;
  assign n_rej    = (head_cmd.hint_min > match_p1) ? head_cmd.hint_min : match_p1;
  assign bytes_sum = {1'b0, bytes_r} + {{(IDX_W + 1 - BYTES_W){1'b0}}, head_cmd.bytes};
  assign bytes_sat = bytes_sum[IDX_W] ? '1 : bytes_sum[IDX_W-1:0];

  always_comb begin
    mode_nxt   = mode_r;
    next_nxt   = next_r;
    match_nxt  = match_r;
    pend_nxt   = pend_r;
    commit_nxt = commit_r;
    paused_nxt = paused_r;
    cnt_nxt    = cnt_r;
    bytes_nxt  = bytes_r;
    acc        = 1'b0;
    err        = 1'b0;
    case (head_cmd.op)
      OP_PROBE: begin
        mode_nxt   = MODE_PROBE;
        paused_nxt = 1'b0;
        pend_nxt   = '0;
        cnt_nxt    = '0;
        bytes_nxt  = '0;
        next_nxt   = n_probe;
        commit_nxt = (commit_r < n_probe - IDX_W'(1)) ? commit_r : n_probe - IDX_W'(1);
      end
      OP_REPLICATE: begin
        mode_nxt   = MODE_REPLICATE;
        paused_nxt = 1'b0;
        pend_nxt   = '0;
        cnt_nxt    = '0;
        bytes_nxt  = '0;
        next_nxt   = match_p1;
      end
      OP_SNAPSHOT: begin
        mode_nxt   = MODE_SNAPSHOT;
        paused_nxt = 1'b0;
        cnt_nxt    = '0;
        bytes_nxt  = '0;
        pend_nxt   = head_cmd.idx;
        next_nxt   = head_cmd.idx_p1;
        commit_nxt = head_cmd.idx;
      end
      OP_SENT: begin
        if (mode_r == MODE_SNAPSHOT) begin
          err = 1'b1;
        end else if (mode_r == MODE_PROBE) begin
          if (head_cmd.entries_nz) begin
            paused_nxt = 1'b1;
          end
        end else begin
          if (head_cmd.entries_nz) begin
            next_nxt = next_r + {{(IDX_W - ENTRY_W){1'b0}}, head_cmd.entries};
            if (cnt_r < CNT_W'(INFLIGHT_CAPACITY)) begin
              cnt_nxt   = cnt_r + CNT_W'(1);
              bytes_nxt = bytes_sat;
            end
          end
          // store fullness after the add
          paused_nxt = (cnt_nxt >= CNT_W'(INFLIGHT_CAPACITY)) ||
                       (budget_r != '0 &&
                        bytes_nxt >= {{(IDX_W - BUDGET_W){1'b0}}, budget_r});
        end
      end
      OP_COMMIT: begin
        commit_nxt = head_cmd.idx;
      end
      OP_ACK: begin
        if (head_cmd.idx > match_r) begin
          match_nxt  = head_cmd.idx;
          next_nxt   = (head_cmd.idx_p1 > next_r) ? head_cmd.idx_p1 : next_r;
          paused_nxt = 1'b0;
          acc        = 1'b1;
        end
      end
      OP_REJECT: begin
        if (mode_r == MODE_REPLICATE) begin
          if (head_cmd.idx > match_r) begin
            next_nxt   = match_p1;
            commit_nxt = (commit_r < match_r) ? commit_r : match_r;
            acc        = 1'b1;
          end
        end else if (next_m1 == head_cmd.idx) begin
          next_nxt   = n_rej;
          commit_nxt = (commit_r < n_rej - IDX_W'(1)) ? commit_r : n_rej - IDX_W'(1);
          paused_nxt = 1'b0;
          acc        = 1'b1;
        end
      end
      default: begin
        acc = (head_cmd.idx > commit_r) && (commit_r < next_m1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r    <= '0;
      mode_r      <= MODE_PROBE;
      next_r      <= IDX_W'(1);
      match_r     <= '0;
      pend_r      <= '0;
      commit_r    <= '0;
      paused_r    <= 1'b0;
      cnt_r       <= '0;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        budget_r <= cfg_data;
      end
      if (q_pop) begin
        mode_r      <= mode_nxt;
        next_r      <= next_nxt;
        match_r     <= match_nxt;
        pend_r      <= pend_nxt;
        commit_r    <= commit_nxt;
        paused_r    <= paused_nxt;
        cnt_r       <= cnt_nxt;
        bytes_r     <= bytes_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_mode_r   <= mode_nxt;
      out_next_r   <= next_nxt;
      out_match_r  <= match_nxt;
      out_commit_r <= commit_nxt;
      out_acc_r    <= acc;
      out_paused_r <= (mode_nxt == MODE_SNAPSHOT) || paused_nxt;
      out_err_r    <= err;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_mode_now          = out_mode_r;
  assign out_next_index        = out_next_r;
  assign out_match_index       = out_match_r;
  assign out_commit_sent_index = out_commit_r;
  assign out_accepted          = out_acc_r;
  assign out_paused            = out_paused_r;
  assign out_error_flag        = out_err_r;

`ifndef SYNTHESIS
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(INFLIGHT_CAPACITY))
    else $error("in-flight count above capacity");

  a_snap_paused: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mode_r == MODE_SNAPSHOT) |-> out_paused_r)
    else $error("snapshot result not paused");

  a_err_state: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && err) |=> (mode_r == $past(mode_r) && next_r == $past(next_r) &&
                        cnt_r == $past(cnt_r)))
    else $error("error event changed state");
`endif

endmodule

>>> hw/rtl/replication_progress_tracker.sv
// ----------------------------------------------------------------------------
// replication_progress_tracker: leader-side replication progress for one follower
// path: input is written to the queue, then the state update registers the result
// throughput: one event per cycle unless the output stalls, set by the back-end update
// reset: synchronous active-low rst_n; probe mode, next = 1, all else zero, no budget
// ----------------------------------------------------------------------------
module replication_progress_tracker import rpt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // configuration write: in-flight byte budget
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BUDGET_W-1:0] cfg_data,
  // event input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_opcode,
  input  logic [IDX_W-1:0]    in_log_index,
  input  logic [IDX_W-1:0]    in_hint_index,
  input  logic [ENTRY_W-1:0]  in_entry_count,
  input  logic [BYTES_W-1:0]  in_byte_count,
  // result output
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_mode_now,
  output logic [IDX_W-1:0]    out_next_index,
  output logic [IDX_W-1:0]    out_match_index,
  output logic [IDX_W-1:0]    out_commit_sent_index,
  output logic                out_accepted,
  output logic                out_paused,
  output logic                out_error_flag
);

  // front to queue
  logic      q_push;
  cmd_t      q_cmd;
  // queue to back
  q_status_t q_status;
  cmd_t      head_cmd;
  logic      q_pop;

  // budget register takes a write on any cycle
  assign cfg_ready = 1'b1;

  // front: takes an input transfer whenever the queue has a free slot,
  // does the index arithmetic that does not depend on tracker state
  rpt_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_log_index   (in_log_index),
    .in_hint_index  (in_hint_index),
    .in_entry_count (in_entry_count),
    .in_byte_count  (in_byte_count),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  // short queue so a stalled output does not stop input transfers at once
  rpt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  // back: executes the head event on the progress state and registers the
  // result; pops whenever the output register is empty or being drained
  rpt_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_data              (cfg_data),
    .q_status              (q_status),
    .head_cmd              (head_cmd),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_mode_now          (out_mode_now),
    .out_next_index        (out_next_index),
    .out_match_index       (out_match_index),
    .out_commit_sent_index (out_commit_sent_index),
    .out_accepted          (out_accepted),
    .out_paused            (out_paused),
    .out_error_flag        (out_error_flag)
  );

endmodule

>>> verif/tb_replication_progress_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_replication_progress_tracker: self-checking bench for the progress tracker
// a short table of hand-checked events scored against typed results, then state-aware random
// events across several byte budgets, scored against a cycle-free model of the tracker
// ----------------------------------------------------------------------------
module tb_replication_progress_tracker;
  import rpt_pkg::*;

  localparam logic [IDX_W-1:0] ALL_ONES   = '1;
  localparam int unsigned      RUN_LIMIT  = 200000;
  localparam int unsigned      LONG_HOLD  = 200;
  localparam int unsigned      SETTLE     = 4;      // margin past the queue and result registers

  // one result transfer, field for field as it leaves the block
  typedef struct packed {
    mode_t            mode_now;
    logic [IDX_W-1:0] next_idx;
    logic [IDX_W-1:0] match_idx;
    logic [IDX_W-1:0] commit_idx;
    logic             accepted;
    logic             paused;
    logic             err_flag;
  } tracker_result_t;

  // one stimulus row; want is used only when typed is set
  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   log_idx;
    logic [IDX_W-1:0]   hint;
    logic [ENTRY_W-1:0] entries;
    logic [BYTES_W-1:0] nbytes;
    logic               typed;
    tracker_result_t    want;
  } event_row_t;

  // opening events, walked in order right after reset with no byte budget
  localparam event_row_t OPENING_ROWS [25] = '{
    // fresh state: query never true, sends of nothing change nothing
    '{OP_QUERY,  64'd0, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_PROBE, 64'd1, 64'd0, 64'd0, 1'b0, 1'b0, 1'b0}},
    '{OP_QUERY,  ALL_ONES, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_PROBE, 64'd1, 64'd0, 64'd0, 1'b0, 1'b0, 1'b0}},
    '{OP_SENT,   64'd0, 64'd0, 16'd0, 32'hFFFF_FFFF, 1'b1,
      '{MODE_PROBE, 64'd1, 64'd0, 64'd0, 1'b0, 1'b0, 1'b0}},
    // a real send while probing pauses the flow
    '{OP_SENT,   64'd0, 64'd0, 16'hFFFF, 32'd0, 1'b1,
      '{MODE_PROBE, 64'd1, 64'd0, 64'd0, 1'b0, 1'b1, 1'b0}},
    '{OP_ACK,    64'd0, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_PROBE, 64'd1, 64'd0, 64'd0, 1'b0, 1'b1, 1'b0}},
    // reject at next-1 with an all-ones hint: hint+1 wraps to zero
    '{OP_REJECT, 64'd0, ALL_ONES, 16'd0, 32'd0, 1'b1,
      '{MODE_PROBE, 64'd1, 64'd0, 64'd0, 1'b1, 1'b0, 1'b0}},
    '{OP_REJECT, 64'd7, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_PROBE, 64'd1, 64'd0, 64'd0, 1'b0, 1'b0, 1'b0}},
    '{OP_ACK,    64'd10, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_PROBE, 64'd11, 64'd10, 64'd0, 1'b1, 1'b0, 1'b0}},
    '{OP_COMMIT, 64'd4, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_PROBE, 64'd11, 64'd10, 64'd4, 1'b0, 1'b0, 1'b0}},
    '{OP_QUERY,  64'd5, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_PROBE, 64'd11, 64'd10, 64'd4, 1'b1, 1'b0, 1'b0}},
    '{OP_QUERY,  64'd4, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_PROBE, 64'd11, 64'd10, 64'd4, 1'b0, 1'b0, 1'b0}},
    '{OP_REPLICATE, 64'd0, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_REPLICATE, 64'd11, 64'd10, 64'd4, 1'b0, 1'b0, 1'b0}},
    '{OP_SENT,   64'd0, 64'd0, 16'd5, 32'd100, 1'b1,
      '{MODE_REPLICATE, 64'd16, 64'd10, 64'd4, 1'b0, 1'b0, 1'b0}},
    '{OP_SENT,   64'd0, 64'd0, 16'd0, 32'd50, 1'b1,
      '{MODE_REPLICATE, 64'd16, 64'd10, 64'd4, 1'b0, 1'b0, 1'b0}},
    // stale reject in replicate is ignored, a fresh one rewinds next
    '{OP_REJECT, 64'd10, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_REPLICATE, 64'd16, 64'd10, 64'd4, 1'b0, 1'b0, 1'b0}},
    '{OP_REJECT, 64'd12, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_REPLICATE, 64'd11, 64'd10, 64'd4, 1'b1, 1'b0, 1'b0}},
    '{OP_ACK,    64'd20, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_REPLICATE, 64'd21, 64'd20, 64'd4, 1'b1, 1'b0, 1'b0}},
    '{OP_COMMIT, 64'd30, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_REPLICATE, 64'd21, 64'd20, 64'd30, 1'b0, 1'b0, 1'b0}},
    // probe pulls the sent commit down to next-1
    '{OP_PROBE,  64'd0, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_PROBE, 64'd21, 64'd20, 64'd20, 1'b0, 1'b0, 1'b0}},
    '{OP_SNAPSHOT, 64'd50, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_SNAPSHOT, 64'd51, 64'd20, 64'd50, 1'b0, 1'b1, 1'b0}},
    // any send during a snapshot is the error case
    '{OP_SENT,   64'd0, 64'd0, 16'd1, 32'd1, 1'b1,
      '{MODE_SNAPSHOT, 64'd51, 64'd20, 64'd50, 1'b0, 1'b1, 1'b1}},
    // leaving snapshot: the pending index wins over match+1
    '{OP_PROBE,  64'd0, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_PROBE, 64'd51, 64'd20, 64'd50, 1'b0, 1'b0, 1'b0}},
    // snapshot at the top index: next wraps to zero
    '{OP_SNAPSHOT, ALL_ONES, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_SNAPSHOT, 64'd0, 64'd20, ALL_ONES, 1'b0, 1'b1, 1'b0}},
    '{OP_PROBE,  64'd0, 64'd0, 16'd0, 32'd0, 1'b1,
      '{MODE_PROBE, 64'd21, 64'd20, 64'd20, 1'b0, 1'b0, 1'b0}},
    // probe reject whose hint sits below match: match+1 is the floor
    '{OP_REJECT, 64'd20, 64'd3, 16'd0, 32'd0, 1'b1,
      '{MODE_PROBE, 64'd21, 64'd20, 64'd20, 1'b1, 1'b0, 1'b0}}
  };

  // closing events: push match to the top so next+1 arithmetic wraps
  localparam event_row_t CLOSING_ROWS [6] = '{
    '{OP_ACK,       ALL_ONES, 64'd0, 16'd0, 32'd0, 1'b0, '0},
    '{OP_REPLICATE, 64'd0, 64'd0, 16'd0, 32'd0, 1'b0, '0},
    '{OP_SENT,      64'd0, 64'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_REJECT,    ALL_ONES, ALL_ONES, 16'd0, 32'd0, 1'b0, '0},
    '{OP_PROBE,     64'd0, 64'd0, 16'd0, 32'd0, 1'b0, '0},
    '{OP_QUERY,     ALL_ONES, 64'd0, 16'd0, 32'd0, 1'b0, '0}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [BUDGET_W-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [2:0]          in_opcode;
  logic [IDX_W-1:0]    in_log_index;
  logic [IDX_W-1:0]    in_hint_index;
  logic [ENTRY_W-1:0]  in_entry_count;
  logic [BYTES_W-1:0]  in_byte_count;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          out_mode_now;
  logic [IDX_W-1:0]    out_next_index;
  logic [IDX_W-1:0]    out_match_index;
  logic [IDX_W-1:0]    out_commit_sent_index;
  logic                out_accepted;
  logic                out_paused;
  logic                out_error_flag;

  // model of the follower's progress, advanced once per accepted event
  mode_t               peer_mode;
  logic [IDX_W-1:0]    peer_next;
  logic [IDX_W-1:0]    peer_match;
  logic [IDX_W-1:0]    peer_pending;
  logic [IDX_W-1:0]    peer_commit;
  logic                peer_flow_paused;
  int unsigned         peer_inflight;
  logic [IDX_W-1:0]    peer_inflight_bytes;
  logic [BUDGET_W-1:0] peer_budget;

  tracker_result_t     pending_results [$];   // expected results, oldest first
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;
  bit                  send_idle_en = 1'b0;
  bit                  recv_idle_en = 1'b0;
  bit                  hold_request = 1'b0;

  replication_progress_tracker DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_opcode             (in_opcode),
    .in_log_index          (in_log_index),
    .in_hint_index         (in_hint_index),
    .in_entry_count        (in_entry_count),
    .in_byte_count         (in_byte_count),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_mode_now          (out_mode_now),
    .out_next_index        (out_next_index),
    .out_match_index       (out_match_index),
    .out_commit_sent_index (out_commit_sent_index),
    .out_accepted          (out_accepted),
    .out_paused            (out_paused),
    .out_error_flag        (out_error_flag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends here
  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // progress model
  // ---------------------------------------------------------------------------

  function automatic logic [IDX_W-1:0] larger(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [IDX_W-1:0] smaller(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // any mode change restarts flow control and empties the in-flight store
  function automatic void restart_flow(mode_t m);
    peer_mode           = m;
    peer_flow_paused    = 1'b0;
    peer_pending        = '0;
    peer_inflight       = 0;
    peer_inflight_bytes = '0;
  endfunction

  function automatic void reset_progress();
    restart_flow(MODE_PROBE);
    peer_next   = 64'd1;
    peer_match  = '0;
    peer_commit = '0;
    peer_budget = '0;
  endfunction

  function automatic tracker_result_t advance_progress(op_t op, logic [IDX_W-1:0] log_idx,
                                                       logic [IDX_W-1:0] hint,
                                                       logic [ENTRY_W-1:0] entries,
                                                       logic [BYTES_W-1:0] nbytes);
    tracker_result_t res;
    logic [IDX_W-1:0] probe_next;
    logic [IDX_W:0]   byte_sum;
    res = '0;
    case (op)
      OP_PROBE: begin
        probe_next = (peer_mode == MODE_SNAPSHOT) ?
                     larger(peer_match + 64'd1, peer_pending + 64'd1) : peer_match + 64'd1;
        restart_flow(MODE_PROBE);
        peer_next   = probe_next;
        peer_commit = smaller(peer_commit, peer_next - 64'd1);
      end
      OP_REPLICATE: begin
        restart_flow(MODE_REPLICATE);
        peer_next = peer_match + 64'd1;
      end
      OP_SNAPSHOT: begin
        restart_flow(MODE_SNAPSHOT);
        peer_pending = log_idx;
        peer_next    = log_idx + 64'd1;
        peer_commit  = log_idx;
      end
      OP_SENT: begin
        if (peer_mode == MODE_SNAPSHOT) begin
          res.err_flag = 1'b1;
        end else if (peer_mode == MODE_PROBE) begin
          if (entries != '0) peer_flow_paused = 1'b1;
        end else begin
          if (entries != '0) begin
            peer_next = peer_next + IDX_W'(entries);
            // at capacity the message is dropped from the store, next still moves
            if (peer_inflight < INFLIGHT_CAPACITY) begin
              peer_inflight++;
              byte_sum = {1'b0, peer_inflight_bytes} + (IDX_W + 1)'(nbytes);
              peer_inflight_bytes = byte_sum[IDX_W] ? ALL_ONES : byte_sum[IDX_W-1:0];
            end
          end
          peer_flow_paused = (peer_inflight >= INFLIGHT_CAPACITY) ||
                             (peer_budget != '0 && peer_inflight_bytes >= IDX_W'(peer_budget));
        end
      end
      OP_COMMIT: peer_commit = log_idx;
      OP_ACK: begin
        if (log_idx > peer_match) begin
          peer_match       = log_idx;
          peer_next        = larger(peer_next, log_idx + 64'd1);
          peer_flow_paused = 1'b0;
          res.accepted     = 1'b1;
        end
      end
      OP_REJECT: begin
        if (peer_mode == MODE_REPLICATE) begin
          if (log_idx > peer_match) begin
            peer_next    = peer_match + 64'd1;
            peer_commit  = smaller(peer_commit, peer_next - 64'd1);
            res.accepted = 1'b1;
          end
        end else if (peer_next - 64'd1 == log_idx) begin
          peer_next        = larger(smaller(log_idx, hint + 64'd1), peer_match + 64'd1);
          peer_commit      = smaller(peer_commit, peer_next - 64'd1);
          peer_flow_paused = 1'b0;
          res.accepted     = 1'b1;
        end
      end
      default: begin
        res.accepted = (log_idx > peer_commit) && (peer_commit < peer_next - 64'd1);
      end
    endcase
    res.mode_now   = peer_mode;
    res.next_idx   = peer_next;
    res.match_idx  = peer_match;
    res.commit_idx = peer_commit;
    res.paused     = (peer_mode == MODE_SNAPSHOT) ? 1'b1 : peer_flow_paused;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // event source
  // ---------------------------------------------------------------------------

  function automatic logic [IDX_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ENTRY_W-1:0] pick_entries();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return ENTRY_W'($urandom);
      default: return ENTRY_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [BYTES_W-1:0] pick_bytes();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return BYTES_W'($urandom_range(1, 4000));
    endcase
  endfunction

  // offer one event and hold it until the transfer; the model advances at
  // the accepting edge so its state always matches what the block has taken
  task automatic offer_event(input op_t op, input logic [IDX_W-1:0] log_idx,
                             input logic [IDX_W-1:0] hint, input logic [ENTRY_W-1:0] entries,
                             input logic [BYTES_W-1:0] nbytes, input logic typed,
                             input tracker_result_t want);
    tracker_result_t predicted;
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_log_index   <= log_idx;
    in_hint_index  <= hint;
    in_entry_count <= entries;
    in_byte_count  <= nbytes;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_progress(op, log_idx, hint, entries, nbytes);
    // hand-checked rows score against the typed value, the model still advances
    pending_results.push_back(typed ? want : predicted);
  endtask

  // random event aimed at the current state, so acks and rejects mostly land
  task automatic offer_random_event();
    op_t              op;
    logic [IDX_W-1:0] log_idx;
    logic [IDX_W-1:0] hint;
    int unsigned      pick;
    pick    = $urandom_range(0, 99);
    log_idx = rand64();
    hint    = rand64();
    if (pick < 5) begin
      op = OP_PROBE;
    end else if (pick < 10) begin
      op = OP_REPLICATE;
    end else if (pick < 13) begin
      op = OP_SNAPSHOT;
      if ($urandom_range(0, 3) != 0) log_idx = peer_match + $urandom_range(0, 200);
    end else if (pick < 43) begin
      op = OP_SENT;
    end else if (pick < 50) begin
      op = OP_COMMIT;
      if ($urandom_range(0, 3) != 0) log_idx = peer_match + $urandom_range(0, 64);
    end else if (pick < 70) begin
      op = OP_ACK;
      case ($urandom_range(0, 19))
        0:       ;                                             // wild jump
        1, 2:    log_idx = peer_match - $urandom_range(0, 3);  // stale ack
        default: log_idx = peer_match + $urandom_range(1, 64);
      endcase
    end else if (pick < 86) begin
      op = OP_REJECT;
      if (peer_mode == MODE_REPLICATE) begin
        if ($urandom_range(0, 7) != 0) log_idx = peer_match + $urandom_range(0, 32);
      end else begin
        // outside replicate, rejects only count at exactly next-1
        log_idx = peer_next - 64'd1;
        if ($urandom_range(0, 3) == 0) log_idx = log_idx + $urandom_range(1, 3);
      end
      case ($urandom_range(0, 3))
        0:       ;
        1:       hint = ALL_ONES;
        2:       hint = log_idx - $urandom_range(0, 20);
        default: hint = peer_match - $urandom_range(0, 5);
      endcase
    end else begin
      op = OP_QUERY;
      if ($urandom_range(0, 3) != 0) log_idx = peer_commit - 64'd1 + $urandom_range(0, 2);
    end
    offer_event(op, log_idx, hint, pick_entries(), pick_bytes(), 1'b0, '0);
  endtask

  // wait for every expected result, then let the pipeline empty
  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // budget writes only happen with the tracker idle
  task automatic write_budget(input logic [BUDGET_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    peer_budget = value;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result sink: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    bit hold_taken;
    hold_taken = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request && !hold_taken) begin
        // long stall while the source keeps offering, so the input backs up
        out_ready  <= 1'b0;
        hold_taken = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (recv_idle_en && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // scoreboard: every result transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [IDX_W-1:0] want,
                               input logic [IDX_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : score_results
    tracker_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_mode_now !== want.mode_now)
          flag_mismatch("mode_now", IDX_W'(want.mode_now), IDX_W'(out_mode_now));
        if (out_next_index !== want.next_idx)
          flag_mismatch("next_index", want.next_idx, out_next_index);
        if (out_match_index !== want.match_idx)
          flag_mismatch("match_index", want.match_idx, out_match_index);
        if (out_commit_sent_index !== want.commit_idx)
          flag_mismatch("commit_sent_index", want.commit_idx, out_commit_sent_index);
        if (out_accepted !== want.accepted)
          flag_mismatch("accepted", IDX_W'(want.accepted), IDX_W'(out_accepted));
        if (out_paused !== want.paused)
          flag_mismatch("paused", IDX_W'(want.paused), IDX_W'(out_paused));
        if (out_error_flag !== want.err_flag)
          flag_mismatch("error_flag", IDX_W'(want.err_flag), IDX_W'(out_error_flag));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    rst_n          <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_PROBE;
    in_log_index   <= '0;
    in_hint_index  <= '0;
    in_entry_count <= '0;
    in_byte_count  <= '0;
    reset_progress();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hand-checked events from the reset state, no byte limit
    write_budget('0);
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    foreach (OPENING_ROWS[i])
      offer_event(OPENING_ROWS[i].op, OPENING_ROWS[i].log_idx, OPENING_ROWS[i].hint,
                  OPENING_ROWS[i].entries, OPENING_ROWS[i].nbytes, OPENING_ROWS[i].typed,
                  OPENING_ROWS[i].want);
    in_valid <= 1'b0;

    // largest budget, with the sink holding off early on
    write_budget('1);
    hold_request = 1'b1;
    repeat (300) offer_random_event();
    in_valid <= 1'b0;

    // smallest nonzero budget: any bytes in flight fill the store
    write_budget(BUDGET_W'(1));
    repeat (200) offer_random_event();
    in_valid <= 1'b0;

    // no byte limit: offer more sends than the in-flight capacity in one replicate stretch
    write_budget('0);
    offer_event(OP_REPLICATE, '0, '0, '0, '0, 1'b0, '0);
    repeat (INFLIGHT_CAPACITY + 14)
      offer_event(OP_SENT, rand64(), rand64(), ENTRY_W'($urandom_range(1, 4)), pick_bytes(),
                  1'b0, '0);
    in_valid <= 1'b0;

    // mid-range budget, idling stops for the last stretch
    write_budget(BUDGET_W'($urandom_range(1000, 100000)));
    repeat (100) offer_random_event();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    repeat (150) offer_random_event();
    foreach (CLOSING_ROWS[i])
      offer_event(CLOSING_ROWS[i].op, CLOSING_ROWS[i].log_idx, CLOSING_ROWS[i].hint,
                  CLOSING_ROWS[i].entries, CLOSING_ROWS[i].nbytes, CLOSING_ROWS[i].typed,
                  CLOSING_ROWS[i].want);
    in_valid <= 1'b0;

    drain_results();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/rpt_pkg.sv
hw/rtl/rpt_front.sv
hw/rtl/rpt_queue.sv
hw/rtl/rpt_back.sv
hw/rtl/replication_progress_tracker.sv
verif/tb_replication_progress_tracker.sv
